// File: rtl/lzwd_pkg.sv
// Shared constants and port structs of the LZSS window decompressor.
package lzwd_pkg;

    // History window; the distance field of a copy addresses all of it.
    localparam int HIST_DEPTH = 2048;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    // A distance runs from 1 up to the full depth, so it needs one more bit.
    localparam int DIST_W     = HIST_AW + 1;

    localparam int WORD_W     = 8;
    localparam int COUNT_W    = 16;
    localparam int LEN_W      = 6;
    localparam int ITEMS_W    = 4;

    // Exact token word that closes a stream.
    localparam logic [WORD_W-1:0]  END_TOKEN   = 8'h1F;
    // Number of items announced by one flag word.
    localparam logic [ITEMS_W-1:0] GROUP_ITEMS = 4'd8;
    // Copy length is the token's low five bits plus this bias.
    localparam logic [LEN_W-1:0]   LEN_BIAS    = 6'd3;

    typedef struct packed {
        logic               en;
        logic [HIST_AW-1:0] addr;
        logic [WORD_W-1:0]  data;
    } hist_wr_t;

    typedef struct packed {
        logic               en;
        logic [HIST_AW-1:0] addr;
    } hist_rd_t;

endpackage

// File: rtl/lzwd_history.sv
// History window memory: one write port and one read port with registered data.
module lzwd_history (
    input  logic                            aclk,
    input  lzwd_pkg::hist_wr_t              wr,
    input  lzwd_pkg::hist_rd_t              rd,
    output logic [lzwd_pkg::WORD_W-1:0]     rd_data
);
    import lzwd_pkg::*;

    logic [WORD_W-1:0] mem [HIST_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read data holds until the next read, so a stalled consumer sees it stay.
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/lz_window_decompressor_core.sv
// LZSS decompressor core with a 2048-word history window and its control sequencer.
//
// The input channel (s_valid, s_ready, s_in_byte) takes one compressed word at a time.
// Each group starts with a flag word read most significant bit first; a clear bit
// announces a literal word, a set bit a token word (then a distance low word unless 0x1F).
// The result channel (m_valid, m_ready and the m_ fields) delivers decompressed words,
// each with its running count; m_run_last marks the last word caused by one input word.
// Token 0x1F delivers a single end word (m_stream_end) carrying the final count.
// A copy whose distance reaches past the words produced in this stream delivers zeros
// with m_bad_distance set; they still enter the window and the count.
// Flag words and copy token words are taken in idle. A literal or an end token is
// taken, then loaded into the output register in a state of its own. Each copied word
// goes through a window read state and then a state that writes it back and loads the
// output register; that read-then-write loop through the single window memory lets
// overlapping copies see their own words. s_ready is high only while the sequencer is idle.
// A stalled receiver holds the output register full; the sequencer waits in the state
// that loads the output and resumes the cycle m_ready returns. Synchronous active-low
// reset clears the parser, count and pointer; window contents stay undefined until written.
module lz_window_decompressor_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [lzwd_pkg::WORD_W-1:0]     s_in_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lzwd_pkg::WORD_W-1:0]     m_out_byte,
    output logic                            m_run_last,
    output logic                            m_stream_end,
    output logic                            m_bad_distance,
    output logic [lzwd_pkg::COUNT_W-1:0]    m_out_count
);
    import lzwd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIT,
        ST_END,
        ST_READ,
        ST_WRITE
    } state_t;

    typedef enum logic [1:0] {
        PH_FLAG = 2'd0,
        PH_ITEM = 2'd1,
        PH_DIST = 2'd2
    } phase_t;

    state_t               state_reg,     state_next;
    phase_t               phase_reg,     phase_next;
    logic [WORD_W-1:0]    flag_reg,      flag_next;
    logic [ITEMS_W-1:0]   items_reg,     items_next;
    logic [WORD_W-1:0]    token_reg,     token_next;
    logic [WORD_W-1:0]    lit_reg,       lit_next;
    logic [HIST_AW-1:0]   offset_reg,    offset_next;
    logic [LEN_W-1:0]     len_left_reg,  len_left_next;
    logic                 bad_reg,       bad_next;
    logic [HIST_AW-1:0]   wp_reg,        wp_next;
    logic [COUNT_W-1:0]   count_reg,     count_next;
    logic                 full_reg,      full_next;

    logic                 m_valid_reg,   m_valid_next;
    logic [WORD_W-1:0]    m_byte_reg,    m_byte_next;
    logic                 m_last_reg,    m_last_next;
    logic                 m_end_reg,     m_end_next;
    logic                 m_bad_reg,     m_bad_next;
    logic [COUNT_W-1:0]   m_count_reg,   m_count_next;

    hist_wr_t             hist_wr;
    hist_rd_t             hist_rd;
    logic [WORD_W-1:0]    hist_rd_data;

    logic                 out_free;
    logic                 accept;
    logic [HIST_AW-1:0]   dist_code;
    logic [DIST_W-1:0]    copy_dist;

    // Word production shared by literals and copies.
    logic                 prod_en;
    logic [WORD_W-1:0]    prod_byte;
    logic                 prod_bad;
    logic                 prod_last;
    logic                 prod_item_done;
    logic [COUNT_W-1:0]   count_inc;
    logic [ITEMS_W-1:0]   items_dec;

    lzwd_history u_history (
        .aclk    (aclk),
        .wr      (hist_wr),
        .rd      (hist_rd),
        .rd_data (hist_rd_data)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;

    // The distance word is HIST_DEPTH minus {token high bits, low word}; reading
    // back by that distance is the same as reading forward by the code itself.
    assign dist_code = {token_reg[7:5], s_in_byte};
    assign copy_dist = DIST_W'(HIST_DEPTH) - {1'b0, dist_code};

    assign count_inc = count_reg + 1'b1;
    assign items_dec = items_reg - 1'b1;

    always_comb begin
        prod_en        = 1'b0;
        prod_byte      = lit_reg;
        prod_bad       = 1'b0;
        prod_last      = 1'b1;
        prod_item_done = 1'b0;
        hist_rd.en     = 1'b0;
        hist_rd.addr   = wp_reg + offset_reg;

        state_next     = state_reg;
        phase_next     = phase_reg;
        flag_next      = flag_reg;
        items_next     = items_reg;
        token_next     = token_reg;
        lit_next       = lit_reg;
        offset_next    = offset_reg;
        len_left_next  = len_left_reg;
        bad_next       = bad_reg;
        wp_next        = wp_reg;
        count_next     = count_reg;
        full_next      = full_reg;

        m_valid_next   = m_valid_reg && !m_ready;
        m_byte_next    = m_byte_reg;
        m_last_next    = m_last_reg;
        m_end_next     = m_end_reg;
        m_bad_next     = m_bad_reg;
        m_count_next   = m_count_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (phase_reg)
                        PH_ITEM: begin
                            if (!flag_reg[7]) begin
                                lit_next   = s_in_byte;
                                state_next = ST_LIT;
                            end else if (s_in_byte == END_TOKEN) begin
                                state_next = ST_END;
                            end else begin
                                token_next = s_in_byte;
                                phase_next = PH_DIST;
                            end
                        end
                        PH_DIST: begin
                            offset_next   = dist_code;
                            len_left_next = LEN_W'(token_reg[4:0]) + LEN_BIAS;
                            bad_next      = !full_reg &&
                                            (COUNT_W'(copy_dist) > count_reg);
                            state_next    = ST_READ;
                        end
                        default: begin
                            // Flag phase, and the unused phase code behaves the same.
                            flag_next  = s_in_byte;
                            items_next = GROUP_ITEMS;
                            phase_next = PH_ITEM;
                        end
                    endcase
                end
            end
            ST_LIT: begin
                if (out_free) begin
                    prod_en        = 1'b1;
                    prod_item_done = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_END: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = '0;
                    m_last_next  = 1'b1;
                    m_end_next   = 1'b1;
                    m_bad_next   = 1'b0;
                    m_count_next = count_reg;
                    count_next   = '0;
                    full_next    = 1'b0;
                    flag_next    = '0;
                    items_next   = '0;
                    phase_next   = PH_FLAG;
                    state_next   = ST_IDLE;
                end
            end
            ST_READ: begin
                hist_rd.en = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (out_free) begin
                    prod_en       = 1'b1;
                    prod_byte     = bad_reg ? '0 : hist_rd_data;
                    prod_bad      = bad_reg;
                    prod_last     = (len_left_reg == LEN_W'(1));
                    len_left_next = len_left_reg - 1'b1;
                    if (prod_last) begin
                        prod_item_done = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (prod_en) begin
            wp_next      = wp_reg + 1'b1;
            count_next   = count_inc;
            if (count_inc == COUNT_W'(HIST_DEPTH)) begin
                full_next = 1'b1;
            end
            m_valid_next = 1'b1;
            m_byte_next  = prod_byte;
            m_last_next  = prod_last;
            m_end_next   = 1'b0;
            m_bad_next   = prod_bad;
            m_count_next = count_inc;
        end

        if (prod_item_done) begin
            flag_next  = {flag_reg[6:0], 1'b0};
            items_next = items_dec;
            phase_next = (items_dec == '0) ? PH_FLAG : PH_ITEM;
        end

        hist_wr.en   = prod_en;
        hist_wr.addr = wp_reg;
        hist_wr.data = prod_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_FLAG;
            flag_reg     <= '0;
            items_reg    <= '0;
            token_reg    <= '0;
            len_left_reg <= '0;
            bad_reg      <= 1'b0;
            wp_reg       <= '0;
            count_reg    <= '0;
            full_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            flag_reg     <= flag_next;
            items_reg    <= items_next;
            token_reg    <= token_next;
            len_left_reg <= len_left_next;
            bad_reg      <= bad_next;
            wp_reg       <= wp_next;
            count_reg    <= count_next;
            full_reg     <= full_next;
            m_valid_reg  <= m_valid_next;
        end
        // Payload registers carry no reset.
        lit_reg     <= lit_next;
        offset_reg  <= offset_next;
        m_byte_reg  <= m_byte_next;
        m_last_reg  <= m_last_next;
        m_end_reg   <= m_end_next;
        m_bad_reg   <= m_bad_next;
        m_count_reg <= m_count_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = m_byte_reg;
    assign m_run_last     = m_last_reg;
    assign m_stream_end   = m_end_reg;
    assign m_bad_distance = m_bad_reg;
    assign m_out_count    = m_count_reg;

    // A window write always goes with a load of a free output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        hist_wr.en |-> (out_free && m_valid_next))
        else $error("window written without an output load");

    // Every window read is followed by the write-back state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> (state_reg == ST_WRITE))
        else $error("window read not followed by write-back");

    // A copy never runs longer than the longest token allows.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (len_left_reg != '0 && len_left_reg <= LEN_W'(34)))
        else $error("copy length out of range");

    // The sequencer only leaves idle after taking an input word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_IDLE) && !s_valid) |=> (state_reg == ST_IDLE))
        else $error("sequencer left idle without input");

endmodule
